@@ design/prime_counter_trial_division_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the trial-division prime counter
// Shorthand for clocked implications with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef PRIME_COUNTER_TRIAL_DIVISION_MACROS_SVH
`define PRIME_COUNTER_TRIAL_DIVISION_MACROS_SVH

// same-cycle implication
`define PCTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/pctd_pkg.sv @@
// ----------------------------------------------------------------------------
// pctd_pkg
// Widths and transfer types shared by the trial-division prime counter.
// ----------------------------------------------------------------------------
package pctd_pkg;

   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = 17;
   localparam int STEP_BITS  = $clog2(VALUE_BITS);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last_item;
   } pctd_req_type;

   typedef struct packed {
      logic                  is_prime;
      logic [COUNT_BITS-1:0] prime_count;
      logic                  end_of_set;
   } pctd_rsp_type;

   typedef struct packed {
      logic done;
      logic zero;
   } pctd_rem_status_type;

endpackage

@@ design/prime_counter_trial_division.sv @@
// ----------------------------------------------------------------------------
// prime_counter_trial_division
// Primality test by trial division with a running, saturating prime count.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    pctd_req_type (value, last_item)
//   rsp      out  rsp_valid/rsp_ready    pctd_rsp_type (is_prime, prime_count,
//                                                       end_of_set)
//
// One item at a time: S_IDLE takes it, then for each trial divisor d
// (2, 3, ... while d*d <= value) S_CHECK starts the bit-serial remainder
// unit and S_DIV waits for it; a zero remainder, or no divisor left, leads
// to S_DONE. A finished result sits in the output register, so the next
// item is taken while it waits. Reset clears the count and leaves the block
// idle.
// ----------------------------------------------------------------------------
module prime_counter_trial_division
   import pctd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  pctd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pctd_rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic [VALUE_BITS:0] FIRST_SQUARE = (VALUE_BITS + 1)'(4);
   localparam logic [VALUE_BITS-1:0] FIRST_DIV  = VALUE_BITS'(2);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  last_ff, last_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [VALUE_BITS:0]   sq_ff, sq_in;
   logic                  prime_ff, prime_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pctd_rsp_type          rsp_ff, rsp_in;

   logic                  rem_start;
   pctd_rem_status_type   rem_status;
   logic [VALUE_BITS+1:0] sq_sum;
   logic [COUNT_BITS-1:0] count_next;
   logic                  out_free;

   pctd_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (value_ff),
      .divisor  (div_ff),
      .status   (rem_status)
   );

   always_comb begin
      // (d+1)^2 = d^2 + 2d + 1
      sq_sum   = {1'b0, sq_ff} + {1'b0, div_ff, 1'b1};
      out_free = !rsp_valid_ff || rsp_ready;
      if (prime_ff && (count_ff != {COUNT_BITS{1'b1}})) begin
         count_next = count_ff + 1'b1;
      end else begin
         count_next = count_ff;
      end

      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      prime_in     = prime_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rem_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_data.value;
               last_in  = req_data.last_item;
               div_in   = FIRST_DIV;
               sq_in    = FIRST_SQUARE;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sq_ff > {1'b0, value_ff}) begin
               // no divisor left: prime unless zero or one
               prime_in = (value_ff > VALUE_BITS'(1));
               state_in = S_DONE;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  div_in   = div_ff + 1'b1;
                  sq_in    = sq_sum[VALUE_BITS:0];
                  state_in = S_CHECK;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.is_prime    = prime_ff;
               rsp_in.prime_count = count_next;
               rsp_in.end_of_set  = last_ff;
               rsp_valid_in       = 1'b1;
               count_in           = last_ff ? '0 : count_next;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_ff       <= FIRST_DIV;
         value_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         value_ff     <= value_in;
      end
      last_ff  <= last_in;
      sq_ff    <= sq_in;
      prime_ff <= prime_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/pctd_rem.sv @@
// ----------------------------------------------------------------------------
// pctd_rem
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pctd_rem
   import pctd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_BITS-1:0]     dividend,
   input  logic [VALUE_BITS-1:0]     divisor,
   output pctd_rem_status_type       status
);

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic [VALUE_BITS-1:0] rem_next;

   always_comb begin
      trial = {rem_ff, shift_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      // subtract only where the divisor fits
      if (trial >= {1'b0, div_ff}) begin
         rem_next = diff[VALUE_BITS-1:0];
      end else begin
         rem_next = trial[VALUE_BITS-1:0];
      end

      busy_in  = busy_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = rem_next;
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end

      status.done = busy_ff && (step_ff == LAST_STEP);
      status.zero = (rem_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

endmodule

@@ design/pctd_checker.sv @@
// ----------------------------------------------------------------------------
// pctd_checker
// Port-level checks on the prime counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "prime_counter_trial_division_macros.svh"

module pctd_checker
   import pctd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input pctd_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input pctd_rsp_type rsp_data
);

   `PCTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `PCTD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp changed while stalled")
   `PCTD_ASSERT_NOW(a_prime_counted, clock, reset, rsp_valid && rsp_data.is_prime, rsp_data.prime_count != '0, "prime with zero count")
   `PCTD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

endmodule

bind prime_counter_trial_division pctd_checker u_pctd_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trial-division prime counter. A scoreboard
// predicts the prime flag and the running, saturating count of every number
// that is transferred in and checks each result, in order, field by field.
// Both channels idle at random, the result side stalls long enough to fill
// the block, and short sets close with the last-item flag.
// ----------------------------------------------------------------------------
import pctd_pkg::*;

class prime_scoreboard;
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

   logic [COUNT_BITS-1:0] running_count;
   pctd_rsp_type          expected_q[$];
   int                    failures;

   function new();
      running_count = '0;
      failures      = 0;
   endfunction

   function bit is_prime_value(logic [VALUE_BITS-1:0] n);
      int unsigned divisor;
      if (n < 2) return 1'b0;
      for (divisor = 2; divisor * divisor <= n; divisor++)
         if (n % divisor == 0) return 1'b0;
      return 1'b1;
   endfunction

   function void note_request(pctd_req_type item);
      pctd_rsp_type want;
      want.is_prime = is_prime_value(item.value);
      // hold at the top once the counter is full
      if (want.is_prime && running_count != COUNT_LIMIT) running_count++;
      want.prime_count = running_count;
      want.end_of_set  = item.last_item;
      if (item.last_item) running_count = '0;
      expected_q.push_back(want);
   endfunction

   function void check_response(pctd_rsp_type got);
      pctd_rsp_type want;
      if (expected_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result: is_prime=%0d count=%0d end=%0d",
                     got.is_prime, got.prime_count, got.end_of_set);
         return;
      end
      want = expected_q.pop_front();
      if (got.is_prime !== want.is_prime || got.prime_count !== want.prime_count ||
          got.end_of_set !== want.end_of_set) begin
         failures++;
         if (failures <= 10)
            $display("mismatch: expected is_prime=%0d count=%0d end=%0d, got %0d %0d %0d",
                     want.is_prime, want.prime_count, want.end_of_set,
                     got.is_prime, got.prime_count, got.end_of_set);
      end
   endfunction
endclass

module tb_top;

   localparam int HALF_PERIOD    = 5;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 25000;
   localparam int SETTLE_CYCLES  = 5000;
   localparam int DIRECTED_COUNT = 20;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   pctd_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   pctd_rsp_type rsp_data;

   prime_scoreboard sb = new();

   bit send_idle  = 1'b1;
   bit recv_idle  = 1'b1;
   bit hold_rsp   = 1'b0;
   int quiet_cycles = 0;

   // extremes, squares of primes, powers of two and the largest 16-bit prime
   int unsigned directed_values [DIRECTED_COUNT] = '{
      0, 1, 2, 3, 4, 5, 9, 25, 49, 63001,
      65521, 65535, 65534, 32768, 32767, 251, 257, 0, 1, 2
   };
   bit directed_last [DIRECTED_COUNT] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1
   };

   prime_counter_trial_division i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 3))
         0:       return VALUE_BITS'($urandom_range(0, 15));
         1:       return VALUE_BITS'($urandom_range(0, 1023));
         default: return VALUE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // Entered and left at a falling edge; valid stays up after the transfer
   // so that a back-to-back number does not lower and raise it in one step.
   task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic last);
      int gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data.value     <= value;
      req_data.last_item <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_number(pick_value(), $urandom_range(0, 11) == 0);
   endtask

   // result side
   initial begin
      int wait_cycles;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         wait_cycles = recv_idle ? $urandom_range(0, 7) : 0;
         if (hold_rsp) begin
            wait_cycles = LONG_HOLD;
            hold_rsp    = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_number(VALUE_BITS'(directed_values[i]), directed_last[i]);
      drain_results();

      send_random(30);

      // stall the result side while numbers keep coming, so the block fills
      send_idle = 1'b0;
      hold_rsp  = 1'b1;
      for (int i = 0; i < 25; i++)
         send_number(VALUE_BITS'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
      send_idle = 1'b1;

      send_random(25);

      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_random(20);
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_random(20);
      send_number(VALUE_BITS'(65521), 1'b1);
      drain_results();

      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_number(VALUE_BITS'(4), 1'b1);
      send_number(VALUE_BITS'(3), 1'b0);
      send_number(VALUE_BITS'(2), 1'b1);
      drain_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.expected_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
